FILE: src/sseg_pkg.sv
// Shared types and constants of the step sequencer event generator.
// Used by the configuration interface, the top level and the testbench; depends on nothing.
`default_nettype none

package sseg_pkg;

  // Default number of trigger slots in the store.
  localparam int unsigned MAX_STEPS_DEF = 64;

  // Widths fixed by the item fields and registers.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STEP_W     = 7;

  // Register reset values.
  localparam int unsigned STEP_COUNT_RST      = 16;
  localparam logic [5:0]  FIRST_STEP_RST      = 6'd0;
  localparam logic [5:0]  LAST_STEP_RST       = 6'd15;
  localparam logic [7:0]  CLOCK_DIVIDE_RST    = 8'd1;
  localparam logic [15:0] FRAMES_PER_STEP_RST = 16'd4800;

  // MIDI status bases: channel numbers start at one.
  localparam logic [7:0] NOTE_ON_BASE = 8'd143;
  localparam logic [7:0] CC_BASE      = 8'd175;
  localparam logic [6:0] NOTE_MAX     = 7'd127;

  // Half a step in 1/256 step units, the nominal trigger position.
  localparam logic signed [8:0] HALF_STEP_MULT = 9'sd128;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_COUNT      = 3'd0,
    CFG_FIRST_STEP      = 3'd1,
    CFG_LAST_STEP       = 3'd2,
    CFG_CLOCK_DIVIDE    = 3'd3,
    CFG_TRANSPOSE       = 3'd4,
    CFG_MUTE            = 3'd5,
    CFG_OUTPUT_EN       = 3'd6,
    CFG_FRAMES_PER_STEP = 3'd7
  } cfg_idx_e;

  // Item operations.
  typedef enum logic [2:0] {
    OP_WRITE        = 3'd0,
    OP_CLEAR        = 3'd1,
    OP_SET_PLAYHEAD = 3'd2,
    OP_TICK         = 3'd3,
    OP_WINDOW       = 3'd4
  } op_e;

  // Trigger kinds.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_NOTE = 2'd1,
    KIND_CC   = 2'd2
  } kind_e;

  // Sequencer control states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_EMIT
  } state_e;

  // One trigger slot as held in the store.
  typedef struct packed {
    kind_e              kind;
    logic [4:0]         channel;
    logic [6:0]         d1;
    logic [6:0]         d2;
    logic [15:0]        len88;
    logic [7:0]         prob;
    logic signed [7:0]  micro;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // One result item.
  typedef struct packed {
    logic        event_valid;
    logic        event_kind;
    logic [15:0] time_offset;
    logic [7:0]  status_byte;
    logic [6:0]  data1_out;
    logic [6:0]  data2_out;
    logic [23:0] length_frames;
    logic        window_error;
    logic [5:0]  playhead;
  } res_t;

endpackage

`default_nettype wire

FILE: src/sseg_if.sv
// Handshake interfaces of the step sequencer: input items, result items
// and configuration writes. Depends on sseg_pkg for the configuration widths.
`default_nettype none

// Input item channel.
interface sseg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [5:0]  step_idx;
  logic [1:0]  trig_kind;
  logic [4:0]  channel;
  logic [6:0]  data1;
  logic [6:0]  data2;
  logic [15:0] note_len;
  logic [7:0]  probability;
  logic signed [7:0] micro_offset;
  logic [15:0] window_start;
  logic [15:0] window_length;
  logic [7:0]  random_value;

  modport source (
    output valid, op, step_idx, trig_kind, channel, data1, data2, note_len,
           probability, micro_offset, window_start, window_length, random_value,
    input  ready
  );
  modport sink (
    input  valid, op, step_idx, trig_kind, channel, data1, data2, note_len,
           probability, micro_offset, window_start, window_length, random_value,
    output ready
  );
endinterface

// Result item channel.
interface sseg_out_if;
  logic        valid;
  logic        ready;
  logic        event_valid;
  logic        event_kind;
  logic [15:0] time_offset;
  logic [7:0]  status_byte;
  logic [6:0]  data1_out;
  logic [6:0]  data2_out;
  logic [23:0] length_frames;
  logic        window_error;
  logic [5:0]  playhead;

  modport source (
    output valid, event_valid, event_kind, time_offset, status_byte, data1_out,
           data2_out, length_frames, window_error, playhead,
    input  ready
  );
  modport sink (
    input  valid, event_valid, event_kind, time_offset, status_byte, data1_out,
           data2_out, length_frames, window_error, playhead,
    output ready
  );
endinterface

// Configuration write channel.
interface sseg_cfg_if import sseg_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/step_sequencer_event_generator_top.sv
// Top level of the MIDI step sequencer event generator.
// Depends on sseg_pkg, the interfaces in sseg_if.sv and the RAM sseg_ram.
`default_nettype none

// The sequencer keeps one trigger slot per step in a synchronous RAM of MAX_STEPS
// entries, plus a playhead and a clock-divide counter in registers. After reset
// a clearing pass writes every slot to "no trigger"; no item is accepted during
// it, while configuration writes are taken at any time. Items are handled one at
// a time. A trigger write, trigger clear, playhead set, tick or unknown operation
// places its result in the result register, which moves into the output register
// once that is free. A window query that passes the window, mute, output and
// divider checks reads the slot of the current step from the RAM, computes the
// trigger frame in the read state and the note length in the multiply state,
// and its result then goes the same way. The next item is taken as soon as the
// current one is finished, even while its result still waits in the output
// register.

module step_sequencer_event_generator_top import sseg_pkg::*; #(
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sseg_in_if.sink    in_i,
  sseg_out_if.source out_o,
  sseg_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = $clog2(MAX_STEPS);
  localparam logic [STEP_W-1:0] SC_MAX =
      (MAX_STEPS > 127) ? 7'd127 : STEP_W'(MAX_STEPS);
  localparam logic [STEP_W-1:0] SC_RST =
      (MAX_STEPS < STEP_COUNT_RST) ? STEP_W'(MAX_STEPS) : STEP_W'(STEP_COUNT_RST);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_STEPS - 1);

  // Configuration registers.
  logic [STEP_W-1:0] step_count_q;
  logic [5:0]        first_step_q, last_step_q;
  logic [7:0]        clock_divide_q;
  logic signed [7:0] transpose_q;
  logic              mute_q, out_en_q;
  logic [15:0]       fps_q;

  // Sequencer state and per-item registers.
  state_e            state_q, state_d;
  logic [STEP_W-1:0] cur_step_q, cur_step_d;
  logic [7:0]        div_cnt_q, div_cnt_d;
  logic [AW-1:0]     clr_cnt_q;
  logic [15:0]       ws_q;
  logic [16:0]       wend_q;
  logic [7:0]        rnd_q;
  slot_t             slot_q;
  logic              hit_q, hit_d;
  logic [15:0]       frame_q, frame_d;
  res_t              res_q, res_d;
  res_t              out_q;
  logic              out_valid_q;

  // Handshake and RAM signals.
  logic              in_acc, cfg_acc, out_free;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [SLOT_W-1:0] ram_wdata, ram_rdata;
  slot_t             rd_slot, wr_slot;

  // Decode helpers.
  op_e               in_op;
  logic              idx_ok, set_ok, win_err, win_gate;
  logic [16:0]       wend;
  logic [7:0]        div_inc;
  logic [7:0]        step_inc;
  logic [7:0]        mult;
  logic signed [8:0] mult_s;
  logic [23:0]       frame_prod;
  logic [31:0]       len_prod;
  logic signed [8:0] note_s;
  logic [6:0]        note_sat;
  logic              in_win;

  assign in_acc   = in_i.valid && in_i.ready;
  assign cfg_acc  = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_op    = op_e'(in_i.op);
  assign rd_slot  = slot_t'(ram_rdata);

  // Item field checks made in the accepting cycle.
  assign idx_ok   = ({1'b0, in_i.step_idx} < step_count_q) &&
                    (32'(in_i.step_idx) < MAX_STEPS);
  assign set_ok   = {1'b0, in_i.step_idx} < step_count_q;
  assign wend     = {1'b0, in_i.window_start} + {1'b0, in_i.window_length};
  assign win_err  = wend > {1'b0, fps_q};
  assign win_gate = !mute_q && out_en_q && (div_cnt_q == 8'd0) &&
                    (32'(cur_step_q) < MAX_STEPS);

  // Tick arithmetic.
  assign div_inc  = div_cnt_q + 8'd1;
  assign step_inc = {1'b0, cur_step_q} + 8'd1;

  // Trigger frame: frames_per_step * (0.5 + micro/256), rounded down.
  assign mult_s     = HALF_STEP_MULT + {rd_slot.micro[7], rd_slot.micro};
  assign mult       = mult_s[7:0];
  assign frame_prod = 24'(fps_q) * 24'(mult);

  // Note length in frames and transposed, saturated note number.
  assign len_prod = 32'(slot_q.len88) * 32'(fps_q);
  assign note_s   = $signed({2'b00, slot_q.d1}) + $signed({transpose_q[7], transpose_q});
  always_comb begin
    if (note_s < 9'sd0) begin
      note_sat = 7'd0;
    end else if (note_s > $signed({2'b00, NOTE_MAX})) begin
      note_sat = NOTE_MAX;
    end else begin
      note_sat = note_s[6:0];
    end
  end
  assign in_win = (frame_q >= ws_q) && ({1'b0, frame_q} < wend_q);

  // Slot image of a trigger write; an unknown kind is stored as none.
  always_comb begin
    wr_slot         = '0;
    wr_slot.kind    = (in_i.trig_kind == KIND_NOTE || in_i.trig_kind == KIND_CC) ?
                      kind_e'(in_i.trig_kind) : KIND_NONE;
    wr_slot.channel = in_i.channel;
    wr_slot.d1      = in_i.data1;
    wr_slot.d2      = in_i.data2;
    wr_slot.len88   = in_i.note_len;
    wr_slot.prob    = in_i.probability;
    wr_slot.micro   = in_i.micro_offset;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == CLR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_WINDOW && !win_err && win_gate) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_READ: state_d = ST_MUL;
      ST_MUL:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs: handshake, RAM access, playhead and result assembly.
  always_comb begin
    in_i.ready = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = AW'(in_i.step_idx);
    ram_wdata  = '0;
    ram_re     = 1'b0;
    cur_step_d = cur_step_q;
    div_cnt_d  = div_cnt_q;
    res_d      = res_q;
    hit_d      = (rd_slot.kind != KIND_NONE) && (rd_slot.prob >= rnd_q);
    frame_d    = frame_prod[23:8];
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
      end
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_acc) begin
          res_d = '0;
          case (in_op)
            OP_WRITE: begin
              ram_we    = idx_ok;
              ram_wdata = wr_slot;
            end
            OP_CLEAR: begin
              ram_we = idx_ok;
            end
            OP_SET_PLAYHEAD: begin
              if (set_ok) cur_step_d = {1'b0, in_i.step_idx};
            end
            OP_TICK: begin
              if (div_inc >= clock_divide_q) begin
                div_cnt_d = 8'd0;
                if (cur_step_q == {1'b0, last_step_q}) begin
                  cur_step_d = {1'b0, first_step_q};
                end else if (step_inc >= {1'b0, step_count_q}) begin
                  cur_step_d = '0;
                end else begin
                  cur_step_d = step_inc[STEP_W-1:0];
                end
              end else begin
                div_cnt_d = div_inc;
              end
            end
            OP_WINDOW: begin
              res_d.window_error = win_err;
              ram_re = !win_err && win_gate;
            end
            default: ;
          endcase
          res_d.playhead = cur_step_d[5:0];
        end
      end
      ST_MUL: begin
        res_d          = '0;
        res_d.playhead = cur_step_q[5:0];
        if (hit_q && in_win) begin
          res_d.event_valid = 1'b1;
          res_d.time_offset = frame_q - ws_q;
          res_d.data2_out   = slot_q.d2;
          if (slot_q.kind == KIND_NOTE) begin
            res_d.event_kind    = 1'b0;
            res_d.status_byte   = NOTE_ON_BASE + {3'b000, slot_q.channel};
            res_d.data1_out     = note_sat;
            res_d.length_frames = len_prod[31:8];
          end else begin
            res_d.event_kind  = 1'b1;
            res_d.status_byte = CC_BASE + {3'b000, slot_q.channel};
            res_d.data1_out   = slot_q.d1;
          end
        end
      end
      default: ;
    endcase
    // A clock divide write other than zero restarts the divider.
    if (cfg_acc && cfg_idx_e'(cfg_i.index) == CFG_CLOCK_DIVIDE &&
        cfg_i.data[7:0] != 8'd0) begin
      div_cnt_d = '0;
    end
  end

  // Control registers: state, playhead, divider and clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cur_step_q <= '0;
      div_cnt_q  <= '0;
      clr_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      cur_step_q <= cur_step_d;
      div_cnt_q  <= div_cnt_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q   <= SC_RST;
      first_step_q   <= FIRST_STEP_RST;
      last_step_q    <= LAST_STEP_RST;
      clock_divide_q <= CLOCK_DIVIDE_RST;
      transpose_q    <= '0;
      mute_q         <= 1'b0;
      out_en_q       <= 1'b0;
      fps_q          <= FRAMES_PER_STEP_RST;
    end else if (cfg_acc) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_STEP_COUNT: begin
          if (cfg_i.data[6:0] == 7'd0) begin
            step_count_q <= 7'd1;
          end else if (32'(cfg_i.data[6:0]) > MAX_STEPS) begin
            step_count_q <= SC_MAX;
          end else begin
            step_count_q <= cfg_i.data[6:0];
          end
        end
        CFG_FIRST_STEP: begin
          if ({1'b0, cfg_i.data[5:0]} < step_count_q) first_step_q <= cfg_i.data[5:0];
        end
        CFG_LAST_STEP: begin
          if ({1'b0, cfg_i.data[5:0]} < step_count_q) last_step_q <= cfg_i.data[5:0];
        end
        CFG_CLOCK_DIVIDE: begin
          if (cfg_i.data[7:0] != 8'd0) clock_divide_q <= cfg_i.data[7:0];
        end
        CFG_TRANSPOSE:       transpose_q <= $signed(cfg_i.data[7:0]);
        CFG_MUTE:            mute_q      <= cfg_i.data[0];
        CFG_OUTPUT_EN:       out_en_q    <= cfg_i.data[0];
        CFG_FRAMES_PER_STEP: fps_q       <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Per-item payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ws_q   <= in_i.window_start;
      wend_q <= wend;
      rnd_q  <= in_i.random_value;
    end
    if (state_q == ST_READ) begin
      slot_q  <= rd_slot;
      hit_q   <= hit_d;
      frame_q <= frame_d;
    end
    res_q <= res_d;
  end

  // Output register: takes the finished result as soon as it is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) out_q <= res_q;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.event_valid   = out_q.event_valid;
  assign out_o.event_kind    = out_q.event_kind;
  assign out_o.time_offset   = out_q.time_offset;
  assign out_o.status_byte   = out_q.status_byte;
  assign out_o.data1_out     = out_q.data1_out;
  assign out_o.data2_out     = out_q.data2_out;
  assign out_o.length_frames = out_q.length_frames;
  assign out_o.window_error  = out_q.window_error;
  assign out_o.playhead      = out_q.playhead;

  // Trigger store.
  sseg_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_STEPS)
  ) u_trig_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (AW'(cur_step_q)),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: src/sseg_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Holds the trigger store; depends on nothing.
`default_nettype none

module sseg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/sseg_checker.sv
// Port-level checks of the step sequencer top level, and the bind that
// attaches them. Depends on step_sequencer_event_generator_top.
`default_nettype none

module sseg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        event_valid_i,
  input logic        event_kind_i,
  input logic [15:0] time_offset_i,
  input logic [7:0]  status_byte_i,
  input logic [6:0]  data1_out_i,
  input logic [6:0]  data2_out_i,
  input logic [23:0] length_frames_i,
  input logic        window_error_i,
  input logic [5:0]  playhead_i
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(event_valid_i) &&
    $stable(time_offset_i) && $stable(status_byte_i) && $stable(playhead_i) &&
    $stable(length_frames_i))
    else $error("result changed while stalled");

  // Items are handled one at a time: no accept in the cycle after an accept.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item accepted back to back");

  // A result without an event carries zero event fields.
  a_no_event_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !event_valid_i |-> !event_kind_i && time_offset_i == 16'd0 &&
    status_byte_i == 8'd0 && data1_out_i == 7'd0 && data2_out_i == 7'd0 &&
    length_frames_i == 24'd0)
    else $error("event fields set without an event");

  // A window overrun never produces an event.
  a_err_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && window_error_i |-> !event_valid_i)
    else $error("event emitted with window error");

endmodule

bind step_sequencer_event_generator_top sseg_checker u_sseg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .event_valid_i   (out_o.event_valid),
  .event_kind_i    (out_o.event_kind),
  .time_offset_i   (out_o.time_offset),
  .status_byte_i   (out_o.status_byte),
  .data1_out_i     (out_o.data1_out),
  .data2_out_i     (out_o.data2_out),
  .length_frames_i (out_o.length_frames),
  .window_error_i  (out_o.window_error),
  .playhead_i      (out_o.playhead)
);

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the step sequencer event generator.
// Depends on sseg_pkg, the handshake interfaces in sseg_if.sv and the top level.
`default_nettype none

module testbench import sseg_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // One input item as the sender drives it.
  typedef struct packed {
    logic [2:0]        op;
    logic [5:0]        step_idx;
    logic [1:0]        trig_kind;
    logic [4:0]        channel;
    logic [6:0]        data1;
    logic [6:0]        data2;
    logic [15:0]       note_len;
    logic [7:0]        probability;
    logic signed [7:0] micro_offset;
    logic [15:0]       window_start;
    logic [15:0]       window_length;
    logic [7:0]        random_value;
  } seq_cmd_t;

  // Mirrors the sequencer state and queues the event expected for each item.
  class step_event_tracker;
    slot_t       slots [MAX_STEPS_DEF];
    int unsigned step_count, first_step, last_step, clock_divide;
    int unsigned div_count, cur_step, frames_per_step;
    int          transpose;
    bit          mute, out_en;
    res_t        pending_events[$];
    int          mismatches;

    function new();
      foreach (slots[i]) slots[i] = '0;
      step_count      = STEP_COUNT_RST;
      first_step      = FIRST_STEP_RST;
      last_step       = LAST_STEP_RST;
      clock_divide    = CLOCK_DIVIDE_RST;
      frames_per_step = FRAMES_PER_STEP_RST;
      transpose       = 0;
      mute            = 1'b0;
      out_en          = 1'b0;
      div_count       = 0;
      cur_step        = 0;
      mismatches      = 0;
    endfunction

    function int outstanding();
      return pending_events.size();
    endfunction

    // Register write as taken by the block.
    function void apply_register(cfg_idx_e idx, logic [15:0] data);
      int unsigned v;
      case (idx)
        CFG_STEP_COUNT: begin
          v = data[6:0];
          if (v < 1) v = 1;
          if (v > MAX_STEPS_DEF) v = MAX_STEPS_DEF;
          step_count = v;
        end
        CFG_FIRST_STEP: if (data[5:0] < step_count) first_step = data[5:0];
        CFG_LAST_STEP: if (data[5:0] < step_count) last_step = data[5:0];
        CFG_CLOCK_DIVIDE: begin
          if (data[7:0] != 0) begin
            clock_divide = data[7:0];
            div_count    = 0;
          end
        end
        CFG_TRANSPOSE:       transpose = int'($signed(data[7:0]));
        CFG_MUTE:            mute = data[0];
        CFG_OUTPUT_EN:       out_en = data[0];
        CFG_FRAMES_PER_STEP: frames_per_step = data;
        default: ;
      endcase
    endfunction

    // Updates the mirrored state for one item and returns its event.
    function res_t predict_event(seq_cmd_t c);
      res_t            r;
      slot_t           s;
      int unsigned     wend, frame, mult;
      int              n;
      longint unsigned len;
      r = '0;
      case (c.op)
        OP_WRITE: begin
          if (c.step_idx < step_count) begin
            s.kind    = (c.trig_kind == 2'd3) ? KIND_NONE : kind_e'(c.trig_kind);
            s.channel = c.channel;
            s.d1      = c.data1;
            s.d2      = c.data2;
            s.len88   = c.note_len;
            s.prob    = c.probability;
            s.micro   = c.micro_offset;
            slots[c.step_idx] = s;
          end
        end
        OP_CLEAR: if (c.step_idx < step_count) slots[c.step_idx].kind = KIND_NONE;
        OP_SET_PLAYHEAD: if (c.step_idx < step_count) cur_step = c.step_idx;
        OP_TICK: begin
          div_count = (div_count + 1) & 8'hFF;
          if (div_count >= clock_divide) begin
            if (cur_step == last_step) begin
              cur_step = first_step;
            end else begin
              cur_step++;
              if (cur_step >= step_count) cur_step = 0;
            end
            div_count = 0;
          end
        end
        OP_WINDOW: begin
          wend = c.window_start + c.window_length;
          if (wend > frames_per_step) begin
            r.window_error = 1'b1;
          end else if (!mute && out_en && div_count == 0 && cur_step < MAX_STEPS_DEF) begin
            s = slots[cur_step];
            if (s.kind != KIND_NONE && s.prob >= c.random_value) begin
              // Nominal trigger sits half a step in, shifted by the microtiming.
              mult  = 32'(128 + int'($signed(s.micro)));
              frame = (frames_per_step * mult) >> 8;
              if (frame >= c.window_start && frame < wend) begin
                r.event_valid = 1'b1;
                r.time_offset = 16'(frame - c.window_start);
                r.data2_out   = s.d2;
                if (s.kind == KIND_NOTE) begin
                  n = int'(s.d1) + transpose;
                  if (n < 0) n = 0;
                  if (n > 127) n = 127;
                  r.event_kind    = 1'b0;
                  r.status_byte   = NOTE_ON_BASE + 8'(s.channel);
                  r.data1_out     = 7'(n);
                  len             = (longint'(s.len88) * frames_per_step) >> 8;
                  r.length_frames = 24'(len);
                end else begin
                  r.event_kind  = 1'b1;
                  r.status_byte = CC_BASE + 8'(s.channel);
                  r.data1_out   = s.d1;
                end
              end
            end
          end
        end
        default: ;
      endcase
      r.playhead = 6'(cur_step);
      return r;
    endfunction

    function void note_item(seq_cmd_t c);
      pending_events.push_back(predict_event(c));
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        if (mismatches < 10)
          $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_event(res_t got);
      res_t want;
      if (pending_events.size() == 0) begin
        if (mismatches < 10) $display("%0t: result item with nothing expected", $time);
        mismatches++;
        return;
      end
      want = pending_events.pop_front();
      check_field("event_valid", want.event_valid, got.event_valid);
      check_field("event_kind", want.event_kind, got.event_kind);
      check_field("time_offset", want.time_offset, got.time_offset);
      check_field("status_byte", want.status_byte, got.status_byte);
      check_field("data1_out", want.data1_out, got.data1_out);
      check_field("data2_out", want.data2_out, got.data2_out);
      check_field("length_frames", want.length_frames, got.length_frames);
      check_field("window_error", want.window_error, got.window_error);
      check_field("playhead", want.playhead, got.playhead);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sseg_in_if  in_if ();
  sseg_out_if out_if ();
  sseg_cfg_if cfg_if ();

  step_sequencer_event_generator_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  step_event_tracker tracker = new();

  // Idle percentages for the sender and the receiver.
  int   gap_pct;
  int   stall_pct;
  int   stall_left;
  res_t seen;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result receiver: checks each accepted item and stalls in short bursts.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready) begin
      seen.event_valid   = out_if.event_valid;
      seen.event_kind    = out_if.event_kind;
      seen.time_offset   = out_if.time_offset;
      seen.status_byte   = out_if.status_byte;
      seen.data1_out     = out_if.data1_out;
      seen.data2_out     = out_if.data2_out;
      seen.length_frames = out_if.length_frames;
      seen.window_error  = out_if.window_error;
      seen.playhead      = out_if.playhead;
      tracker.check_event(seen);
    end
    if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      out_if.ready <= 1'b0;
      stall_left = $urandom_range(3, 1) - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Drives one item, with an optional gap first, and waits for acceptance.
  task automatic send_item(input seq_cmd_t c);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.op            <= c.op;
    in_if.step_idx      <= c.step_idx;
    in_if.trig_kind     <= c.trig_kind;
    in_if.channel       <= c.channel;
    in_if.data1         <= c.data1;
    in_if.data2         <= c.data2;
    in_if.note_len      <= c.note_len;
    in_if.probability   <= c.probability;
    in_if.micro_offset  <= c.micro_offset;
    in_if.window_start  <= c.window_start;
    in_if.window_length <= c.window_length;
    in_if.random_value  <= c.random_value;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    tracker.note_item(c);
  endtask

  // Register write; the caller lowers valid once its writes are done.
  task automatic write_reg(input cfg_idx_e idx, input int data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= 16'(data);
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    tracker.apply_register(idx, 16'(data));
  endtask

  task automatic end_writes();
    cfg_if.valid <= 1'b0;
  endtask

  // Stops sending and waits until every expected event has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.outstanding() != 0);
  endtask

  function automatic seq_cmd_t trig_cmd(int idx, int kind, int ch, int d1, int d2,
                                        int len, int prob, int micro);
    seq_cmd_t c;
    c              = '0;
    c.op           = OP_WRITE;
    c.step_idx     = 6'(idx);
    c.trig_kind    = 2'(kind);
    c.channel      = 5'(ch);
    c.data1        = 7'(d1);
    c.data2        = 7'(d2);
    c.note_len     = 16'(len);
    c.probability  = 8'(prob);
    c.micro_offset = 8'(micro);
    return c;
  endfunction

  function automatic seq_cmd_t win_cmd(int ws, int wl, int rnd);
    seq_cmd_t c;
    c               = '0;
    c.op            = OP_WINDOW;
    c.window_start  = 16'(ws);
    c.window_length = 16'(wl);
    c.random_value  = 8'(rnd);
    return c;
  endfunction

  function automatic seq_cmd_t ctl_cmd(op_e op, int idx);
    seq_cmd_t c;
    c          = '0;
    c.op       = op;
    c.step_idx = 6'(idx);
    return c;
  endfunction

  // Random item: mostly in-range steps and windows that fit the step.
  function automatic seq_cmd_t rand_item();
    seq_cmd_t    c;
    int unsigned pick, fps, ws;
    fps            = tracker.frames_per_step;
    c.step_idx     = 6'($urandom);
    c.trig_kind    = 2'($urandom);
    c.channel      = 5'($urandom);
    c.data1        = 7'($urandom);
    c.data2        = 7'($urandom);
    c.note_len     = 16'($urandom);
    c.probability  = 8'($urandom);
    c.micro_offset = 8'($urandom);
    c.random_value = 8'($urandom);
    if ($urandom_range(9) < 8) c.step_idx = 6'($urandom_range(tracker.step_count - 1));
    if ($urandom_range(9) < 8) c.trig_kind = 2'($urandom_range(2, 1));
    pick = $urandom_range(9);
    if (pick < 4) begin
      ws              = $urandom_range(fps / 2);
      c.window_start  = 16'(ws);
      c.window_length = 16'(fps - ws);
    end else if (pick < 8) begin
      ws              = $urandom_range(fps);
      c.window_start  = 16'(ws);
      c.window_length = 16'($urandom_range(fps - ws));
    end else begin
      c.window_start  = 16'($urandom);
      c.window_length = 16'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 25)      c.op = OP_WRITE;
    else if (pick < 32) c.op = OP_CLEAR;
    else if (pick < 42) c.op = OP_SET_PLAYHEAD;
    else if (pick < 67) c.op = OP_TICK;
    else if (pick < 95) c.op = OP_WINDOW;
    else                c.op = 3'($urandom_range(7, 5));
    return c;
  endfunction

  task automatic run_random(input int count, input int gaps, input int stalls);
    gap_pct   = gaps;
    stall_pct = stalls;
    repeat (count) send_item(rand_item());
  endtask

  // Stimulus.
  initial begin
    seq_cmd_t c;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.op            = '0;
    in_if.step_idx      = '0;
    in_if.trig_kind     = '0;
    in_if.channel       = '0;
    in_if.data1         = '0;
    in_if.data2         = '0;
    in_if.note_len      = '0;
    in_if.probability   = '0;
    in_if.micro_offset  = '0;
    in_if.window_start  = '0;
    in_if.window_length = '0;
    in_if.random_value  = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_STEP_COUNT;
    cfg_if.data         = '0;
    out_if.ready        = 1'b0;
    gap_pct             = 0;
    stall_pct           = 0;
    stall_left          = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items at the reset register values with an output attached.
    gap_pct   = 20;
    stall_pct = 20;
    write_reg(CFG_OUTPUT_EN, 1);
    end_writes();
    send_item(trig_cmd(0, KIND_NOTE, 1, 60, 100, 16'h0100, 255, 0));
    send_item(win_cmd(0, 4800, 0));
    send_item(trig_cmd(1, KIND_CC, 16, 127, 127, 16'hFFFF, 0, -128));
    send_item(ctl_cmd(OP_TICK, 0));
    send_item(win_cmd(0, 1, 0));
    send_item(win_cmd(0, 1, 1));
    // Window that runs past the end of the step.
    send_item(win_cmd(4800, 1, 0));
    send_item(trig_cmd(15, KIND_NOTE, 31, 0, 0, 16'hFFFF, 255, 127));
    send_item(ctl_cmd(OP_SET_PLAYHEAD, 15));
    send_item(win_cmd(4781, 19, 255));
    // Tick from the loop end back to the loop start.
    send_item(ctl_cmd(OP_TICK, 0));
    // Step indexes beyond the step count are ignored.
    send_item(trig_cmd(16, KIND_NOTE, 2, 1, 1, 1, 255, 0));
    send_item(ctl_cmd(OP_SET_PLAYHEAD, 63));
    send_item(ctl_cmd(OP_CLEAR, 20));
    // Unknown trigger kind is stored as none.
    send_item(trig_cmd(2, 3, 5, 5, 5, 5, 255, 0));
    for (int k = 5; k <= 7; k++) begin
      c    = rand_item();
      c.op = 3'(k);
      send_item(c);
    end
    send_item(ctl_cmd(OP_CLEAR, 0));
    send_item(win_cmd(0, 4800, 0));
    send_item(win_cmd(65535, 65535, 0));

    // Note saturation at both ends of the transpose range.
    drain();
    write_reg(CFG_TRANSPOSE, 127);
    end_writes();
    send_item(trig_cmd(0, KIND_NOTE, 0, 127, 1, 0, 255, 0));
    send_item(win_cmd(0, 4800, 0));
    drain();
    write_reg(CFG_TRANSPOSE, 16'h0080);
    end_writes();
    send_item(win_cmd(0, 4800, 0));

    // Full store, widest step.
    drain();
    write_reg(CFG_STEP_COUNT, 64);
    write_reg(CFG_LAST_STEP, 63);
    write_reg(CFG_FIRST_STEP, 0);
    write_reg(CFG_CLOCK_DIVIDE, 1);
    write_reg(CFG_TRANSPOSE, 0);
    write_reg(CFG_FRAMES_PER_STEP, 65535);
    end_writes();
    run_random(300, 20, 20);

    // Short loop inside a small sequence, slower clock and negative transpose.
    drain();
    write_reg(CFG_STEP_COUNT, 8);
    write_reg(CFG_FIRST_STEP, 2);
    write_reg(CFG_LAST_STEP, 5);
    write_reg(CFG_CLOCK_DIVIDE, 3);
    write_reg(CFG_TRANSPOSE, 16'hFFF9);
    write_reg(CFG_FRAMES_PER_STEP, 1000);
    end_writes();
    run_random(300, 40, 0);

    // Step count clamped to one, ignored writes and a one-frame step.
    drain();
    write_reg(CFG_STEP_COUNT, 0);
    write_reg(CFG_FIRST_STEP, 5);
    write_reg(CFG_LAST_STEP, 0);
    write_reg(CFG_CLOCK_DIVIDE, 0);
    write_reg(CFG_FRAMES_PER_STEP, 1);
    end_writes();
    run_random(150, 0, 40);

    // Step count clamped to the store size and an empty step.
    drain();
    write_reg(CFG_STEP_COUNT, 127);
    write_reg(CFG_FRAMES_PER_STEP, 0);
    end_writes();
    run_random(50, 10, 10);

    // Slowest clock divide and highest transpose.
    drain();
    write_reg(CFG_STEP_COUNT, 32);
    write_reg(CFG_FIRST_STEP, 40);
    write_reg(CFG_FIRST_STEP, 10);
    write_reg(CFG_LAST_STEP, 31);
    write_reg(CFG_CLOCK_DIVIDE, 255);
    write_reg(CFG_TRANSPOSE, 127);
    write_reg(CFG_FRAMES_PER_STEP, 256);
    end_writes();
    run_random(150, 20, 20);

    // Muted.
    drain();
    write_reg(CFG_CLOCK_DIVIDE, 1);
    write_reg(CFG_MUTE, 1);
    end_writes();
    run_random(150, 30, 30);

    // No output attached.
    drain();
    write_reg(CFG_MUTE, 0);
    write_reg(CFG_OUTPUT_EN, 0);
    end_writes();
    run_random(100, 20, 20);

    // Playhead left beyond a shrunken step count.
    drain();
    write_reg(CFG_OUTPUT_EN, 1);
    write_reg(CFG_STEP_COUNT, 20);
    write_reg(CFG_FIRST_STEP, 3);
    write_reg(CFG_LAST_STEP, 17);
    write_reg(CFG_CLOCK_DIVIDE, 2);
    write_reg(CFG_TRANSPOSE, 12);
    write_reg(CFG_FRAMES_PER_STEP, 4800);
    end_writes();
    run_random(200, 20, 20);
    send_item(ctl_cmd(OP_SET_PLAYHEAD, 19));
    drain();
    write_reg(CFG_STEP_COUNT, 10);
    end_writes();
    run_random(200, 20, 20);

    // Closing stretch at full rate on both sides.
    drain();
    write_reg(CFG_STEP_COUNT, 16);
    write_reg(CFG_FIRST_STEP, 0);
    write_reg(CFG_LAST_STEP, 15);
    write_reg(CFG_CLOCK_DIVIDE, 1);
    write_reg(CFG_TRANSPOSE, 0);
    end_writes();
    run_random(300, 0, 0);

    drain();
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
